FILE: src/mmr_pkg.sv
package mmr_pkg;

    localparam int COMP_W    = 32;
    localparam int ACC_W     = 40;
    localparam int MAX_LANES = 4;
    localparam int LANE_W    = 2;
    localparam int TDATA_W   = COMP_W * MAX_LANES;
    localparam int CFG_W     = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_OPERATOR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT    = 1'd1;

    localparam logic signed [COMP_W-1:0] COMP_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COMP_W-1:0] COMP_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        OP_MIN  = 3'd0,
        OP_MAX  = 3'd1,
        OP_AVG  = 3'd2,
        OP_SUM  = 3'd3,
        OP_MUL  = 3'd4,
        OP_DIST = 3'd5,
        OP_DIFF = 3'd6
    } t_op;

    // controller -> datapath
    typedef struct packed {
        logic              capture;
        logic              s1_en;
        logic [LANE_W-1:0] lane;
        logic              item_done;
        logic              div_start;
        logic              fin_en;
        logic              out_load;
        logic              clear;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic last;
        logic is_avg;
        logic div_done;
        logic out_free;
    } t_sts;

    function automatic logic signed [COMP_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [COMP_W-1:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = COMP_MAX;
        end else if (v < 64'shFFFF_FFFF_8000_0000) begin
            r = COMP_MIN;
        end else begin
            r = v[COMP_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [ACC_W-1:0] sat40(input logic signed [ACC_W:0] v);
        logic signed [ACC_W-1:0] r;
        if (v > 41'sh07F_FFFF_FFFF) begin
            r = 40'sh7F_FFFF_FFFF;
        end else if (v < 41'sh180_0000_0000) begin
            r = 40'sh80_0000_0000;
        end else begin
            r = v[ACC_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: src/mmr_div.sv
module mmr_div #(
    parameter int DW = 40,
    parameter int VW = 9
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [DW-1:0] i_dividend,
    input  logic [VW-1:0]        i_divisor,
    output logic signed [DW:0]   o_quot,
    output logic                 o_done
);

    localparam int CNT_W = (DW > 1) ? $clog2(DW) : 1;

    logic             r_busy;
    logic             r_done;
    logic             r_neg;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_quo;
    logic [VW-1:0]    r_rem;
    logic [VW-1:0]    r_dsr;

    logic [VW:0]   shift;
    logic [VW:0]   diff;
    logic          n_bit;
    logic [VW-1:0] n_rem;
    logic [DW-1:0] mag;

    // restoring division, one quotient bit per cycle
    assign shift = {r_rem, r_quo[DW-1]};
    assign diff  = shift - {1'b0, r_dsr};
    assign n_bit = (shift >= {1'b0, r_dsr});
    assign n_rem = n_bit ? diff[VW-1:0] : shift[VW-1:0];
    assign mag   = i_dividend[DW-1] ? DW'(-i_dividend) : DW'(i_dividend);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= mag;
            r_rem <= '0;
            r_dsr <= i_divisor;
            r_neg <= i_dividend[DW-1];
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], n_bit};
            r_rem <= n_rem;
        end
    end

    assign o_quot = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    assign o_done = r_done;

endmodule

FILE: src/mmr_dp.sv
module mmr_dp #(
    parameter int LANES       = 4,
    parameter int MAX_SOURCES = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mmr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mmr_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic [mmr_pkg::TDATA_W-1:0]     i_in_data,
    input  logic                            i_in_last,
    input  mmr_pkg::t_cmd                   i_cmd,
    output mmr_pkg::t_sts                   o_sts,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [mmr_pkg::TDATA_W-1:0]     o_out_data,
    output logic                            o_out_changed
);
    import mmr_pkg::*;

    localparam int CW = $clog2(MAX_SOURCES + 1);
    localparam logic [CFG_W-1:0] LANES_C = CFG_W'(LANES);

    // configuration
    logic [CFG_W-1:0] r_cfg_op;
    logic [CFG_W-1:0] r_cfg_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_op  <= CFG_W'(OP_MIN);
            r_cfg_cnt <= CFG_W'(1);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_OPERATOR) r_cfg_op <= i_cfg_data;
            if (i_cfg_idx == REG_COUNT)    r_cfg_cnt <= i_cfg_data;
        end
    end

    // captured beat
    logic signed [COMP_W-1:0] r_in [MAX_LANES];
    logic                     r_last;
    t_op                      r_op;
    logic [CFG_W-1:0]         r_active;
    logic [CFG_W-1:0]         active_c;

    always_comb begin
        if (r_cfg_cnt == '0) begin
            active_c = CFG_W'(1);
        end else if (r_cfg_cnt > LANES_C) begin
            active_c = LANES_C;
        end else begin
            active_c = r_cfg_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            for (int k = 0; k < MAX_LANES; k++) begin
                r_in[k] <= i_in_data[k*COMP_W +: COMP_W];
            end
            r_last   <= i_in_last;
            r_op     <= t_op'(r_cfg_op);
            r_active <= active_c;
        end
    end

    // group bookkeeping
    logic [CW-1:0] r_count;
    logic          r_started;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_count   <= '0;
            r_started <= 1'b0;
        end else if (i_cmd.item_done) begin
            r_started <= 1'b1;
            if (r_count < CW'(MAX_SOURCES)) r_count <= r_count + 1'b1;
        end
    end

    // per-lane state readout
    logic signed [ACC_W-1:0]  acc_v [MAX_LANES];
    logic signed [COMP_W-1:0] min_v [MAX_LANES];
    logic signed [COMP_W-1:0] max_v [MAX_LANES];

    // stage 1: operand select and multiply
    logic                     r_s2_en;
    logic [LANE_W-1:0]        r_s2_lane;
    logic signed [COMP_W-1:0] r_s2_x;
    logic signed [63:0]       r_prod;
    logic signed [COMP_W-1:0] s1_x;
    logic signed [COMP_W-1:0] s1_a;

    assign s1_x = r_in[i_cmd.lane];
    assign s1_a = sat32(64'(acc_v[i_cmd.lane]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_en <= 1'b0;
        end else begin
            r_s2_en <= i_cmd.s1_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_lane <= i_cmd.lane;
        r_s2_x    <= s1_x;
        r_prod    <= 64'(s1_a) * 64'(s1_x);
    end

    // stage 2: fold
    logic signed [ACC_W-1:0]  s2_a;
    logic signed [COMP_W-1:0] s2_mn;
    logic signed [COMP_W-1:0] s2_mx;
    logic signed [ACC_W:0]    s2_sum;
    logic signed [ACC_W:0]    s2_dif;
    logic signed [COMP_W-1:0] s2_mul;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [COMP_W-1:0] n_min;
    logic signed [COMP_W-1:0] n_max;

    assign s2_a   = acc_v[r_s2_lane];
    assign s2_mn  = min_v[r_s2_lane];
    assign s2_mx  = max_v[r_s2_lane];
    assign s2_sum = (ACC_W+1)'(s2_a) + (ACC_W+1)'(r_s2_x);
    assign s2_dif = (ACC_W+1)'(s2_a) - (ACC_W+1)'(r_s2_x);
    assign s2_mul = sat32(r_prod >>> 16);   // arithmetic shift rounds toward minus infinity

    always_comb begin
        if (!r_started) begin
            n_acc = ACC_W'(r_s2_x);
        end else begin
            unique case (r_op)
                OP_AVG, OP_SUM: n_acc = sat40(s2_sum);
                OP_DIFF:        n_acc = sat40(s2_dif);
                OP_MUL:         n_acc = ACC_W'(s2_mul);
                default:        n_acc = s2_a;
            endcase
        end
        n_min = (r_s2_x < s2_mn) ? r_s2_x : s2_mn;
        n_max = (r_s2_x > s2_mx) ? r_s2_x : s2_mx;
    end

    for (genvar j = 0; j < MAX_LANES; j++) begin : g_lane
        if (j < LANES) begin : g_on
            logic signed [ACC_W-1:0]  r_acc;
            logic signed [COMP_W-1:0] r_min;
            logic signed [COMP_W-1:0] r_max;
            logic                     wr;

            assign wr = r_s2_en && (r_s2_lane == LANE_W'(j));

            always_ff @(posedge i_clk) begin
                if (wr) r_acc <= n_acc;
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n || i_cmd.clear) begin
                    r_min <= COMP_MAX;
                    r_max <= COMP_MIN;
                end else if (wr) begin
                    r_min <= n_min;
                    r_max <= n_max;
                end
            end

            assign acc_v[j] = r_acc;
            assign min_v[j] = r_min;
            assign max_v[j] = r_max;
        end else begin : g_off
            assign acc_v[j] = '0;
            assign min_v[j] = COMP_MAX;
            assign max_v[j] = COMP_MIN;
        end
    end

    // final: one lane per step, average through the shared divider
    logic signed [ACC_W:0]    quot;
    logic                     div_done;
    logic signed [COMP_W:0]   span;
    logic signed [COMP_W-1:0] fin_val;
    logic signed [COMP_W-1:0] r_res [MAX_LANES];

    mmr_div #(
        .DW (ACC_W),
        .VW (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (acc_v[i_cmd.lane]),
        .i_divisor  (r_count),
        .o_quot     (quot),
        .o_done     (div_done)
    );

    assign span = (COMP_W+1)'(max_v[i_cmd.lane]) - (COMP_W+1)'(min_v[i_cmd.lane]);

    always_comb begin
        if (CFG_W'(i_cmd.lane) >= r_active) begin
            fin_val = '0;
        end else begin
            unique case (r_op)
                OP_MAX:                  fin_val = max_v[i_cmd.lane];
                OP_AVG:                  fin_val = sat32(64'(quot));
                OP_SUM, OP_MUL, OP_DIFF: fin_val = sat32(64'(acc_v[i_cmd.lane]));
                OP_DIST:                 fin_val = sat32(64'(span));
                default:                 fin_val = min_v[i_cmd.lane];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin_en) r_res[i_cmd.lane] <= fin_val;
    end

    // output register; its data also serves as the previous result
    logic [TDATA_W-1:0] res_packed;
    logic               r_out_valid;
    logic [TDATA_W-1:0] r_out_data;
    logic               r_out_changed;

    always_comb begin
        for (int k = 0; k < MAX_LANES; k++) begin
            res_packed[k*COMP_W +: COMP_W] = r_res[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_data  <= '0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
            r_out_data  <= res_packed;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) r_out_changed <= (res_packed != r_out_data);
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_data    = r_out_data;
    assign o_out_changed = r_out_changed;

    assign o_sts.last     = r_last;
    assign o_sts.is_avg   = (r_op == OP_AVG);
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

endmodule

FILE: src/mmr_ctrl.sv
module mmr_ctrl #(
    parameter int LANES = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  mmr_pkg::t_sts i_sts,
    output mmr_pkg::t_cmd o_cmd
);
    import mmr_pkg::*;

    localparam logic [LANE_W-1:0] LAST_FOLD = LANE_W'(LANES - 1);
    localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(MAX_LANES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FOLD,
        S_FLUSH,
        S_FIN_GO,
        S_FIN_WAIT,
        S_EMIT
    } t_state;

    t_state            r_state;
    logic [LANE_W-1:0] r_lane;
    logic              r_ready;
    logic              fin_ok;

    assign fin_ok = !i_sts.is_avg || i_sts.div_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lane  <= '0;
            r_ready <= 1'b1;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_FOLD;
                        r_lane  <= '0;
                        r_ready <= 1'b0;
                    end
                end
                S_FOLD: begin
                    if (r_lane == LAST_FOLD) begin
                        r_state <= S_FLUSH;
                    end else begin
                        r_lane <= r_lane + 1'b1;
                    end
                end
                S_FLUSH: begin
                    r_lane <= '0;
                    if (i_sts.last) begin
                        r_state <= S_FIN_GO;
                    end else begin
                        r_state <= S_IDLE;
                        r_ready <= 1'b1;
                    end
                end
                S_FIN_GO: begin
                    r_state <= S_FIN_WAIT;
                end
                S_FIN_WAIT: begin
                    if (fin_ok) begin
                        if (r_lane == LAST_LANE) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_lane  <= r_lane + 1'b1;
                            r_state <= S_FIN_GO;
                        end
                    end
                end
                S_EMIT: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                        r_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_ready <= 1'b1;
                end
            endcase
        end
    end

    assign o_in_ready      = r_ready;
    assign o_cmd.capture   = r_ready && i_in_valid;
    assign o_cmd.s1_en     = (r_state == S_FOLD);
    assign o_cmd.lane      = r_lane;
    assign o_cmd.item_done = (r_state == S_FLUSH);
    assign o_cmd.div_start = (r_state == S_FIN_GO) && i_sts.is_avg;
    assign o_cmd.fin_en    = (r_state == S_FIN_WAIT) && fin_ok;
    assign o_cmd.out_load  = (r_state == S_EMIT) && i_sts.out_free;
    assign o_cmd.clear     = (r_state == S_EMIT) && i_sts.out_free;

endmodule

FILE: src/multi_operator_merge_reduction.sv
// Multi-operator merge reduction. Each input beat carries one source value of up to four
// signed Q16.16 components; beats are folded lane by lane under the configured operator
// (min, max, average, sum, multiply, distance = max - min, difference = first - rest).
// Sum, difference and average accumulate in 40 bits with saturation; multiply saturates
// to 32 bits at every step. The beat with tlast closes the group: one result beat follows
// with the merged vector (lanes at or above component_count read 0) and tuser set when it
// differs from the previous result. Other beats produce nothing.
// A beat is accepted in the idle state; one shared fold unit with a single 32x32 multiplier
// visits the lanes one per cycle and a flush state drains its pipeline before the next beat
// is accepted. A closing beat takes a go and a wait state per lane (for average, waiting on
// the bit-serial 40-bit divider), then an emit state loads the output register once free.
// The next group may start while the result beat waits; only a second result stalls on it.
// Configuration must be written only while the block is idle; the block does not enforce it.
module multi_operator_merge_reduction #(
    parameter int LANES       = 4,
    parameter int MAX_SOURCES = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [mmr_pkg::CFG_IDX_W-1:0] i_cfg_idx,   // 0 operator_select, 1 component_count
    input  logic [mmr_pkg::CFG_W-1:0]     i_cfg_data,
    // source beats
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [mmr_pkg::TDATA_W-1:0]   s_axis_tdata,  // comp0, comp1, comp2, comp3
    input  logic                          s_axis_tlast,  // last_source
    // result beats
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [mmr_pkg::TDATA_W-1:0]   m_axis_tdata,  // merged0, merged1, merged2, merged3
    output logic                          m_axis_tuser   // changed
);
    import mmr_pkg::*;

    t_cmd cmd;
    t_sts sts;

    mmr_ctrl #(
        .LANES (LANES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mmr_dp #(
        .LANES       (LANES),
        .MAX_SOURCES (MAX_SOURCES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_data     (s_axis_tdata),
        .i_in_last     (s_axis_tlast),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_out_data    (m_axis_tdata),
        .o_out_changed (m_axis_tuser)
    );

endmodule
